// ===== src/rpn_pkg.sv =====
// shared types, codes and helpers of the rpn stack calculator
package rpn_pkg;

  localparam int StackDepth = 64;
  localparam int AddrW = $clog2(StackDepth);
  localparam int CntW = $clog2(StackDepth + 1);

  typedef enum logic [3:0] {
    KindNumber  = 4'd0,
    KindAdd     = 4'd1,
    KindSub     = 4'd2,
    KindMul     = 4'd3,
    KindDiv     = 4'd4,
    KindMod     = 4'd5,
    KindPeek    = 4'd6,
    KindDup     = 4'd7,
    KindSwap    = 4'd8,
    KindClear   = 4'd9,
    KindShowTop = 4'd10,
    KindUnknown = 4'd11
  } kind_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StEmpty   = 3'd1,
    StFull    = 3'd2,
    StZdiv    = 3'd3,
    StUnknown = 3'd4
  } status_e;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] number_value;
  } rpn_in_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [6:0]         stack_depth;
    logic [2:0]         status;
    logic               show;
  } rpn_out_t;

  // classified command handed from the front to the back
  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] value;
  } rpn_cmd_t;

  localparam int QDepth = 2;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

// ===== src/rpn_front.sv =====
// front end: accepts items, classifies the kind and queues commands
module rpn_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  rpn_pkg::rpn_in_t in_i,
  output logic             busy_o,
  output logic             cmd_valid_o,
  output rpn_pkg::rpn_cmd_t cmd_o,
  input  logic             cmd_pop_i,
  input  logic             back_busy_i
);
  import rpn_pkg::*;

  rpn_cmd_t   q_mem [QDepth];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  kind_e      kind_c;

  always_comb begin
    if (in_i.kind > 4'd10) kind_c = KindUnknown;
    else kind_c = kind_e'(in_i.kind);
  end

  // one item at a time: busy until the back end has delivered
  assign busy_o = (cnt_q != 2'd0) || back_busy_i;
  assign push = start_i && !busy_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o = q_mem[rd_q];

  always_comb begin
    wr_d = push ? ~wr_q : wr_q;
    rd_d = cmd_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= '{kind: kind_c, value: in_i.number_value};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop_i |-> cnt_q != 2'd0)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |=> cnt_q != 2'd0)
    else $error("push lost");
endmodule

// ===== src/rpn_back.sv =====
// back end: stack memory, sequencer and iterative divider
module rpn_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  rpn_pkg::rpn_cmd_t cmd_i,
  output logic              cmd_pop_o,
  output logic              busy_o,
  output logic              done_o,
  output rpn_pkg::rpn_out_t res_o
);
  import rpn_pkg::*;

  typedef enum logic [9:0] {
    SIdle  = 10'b0000000001,
    SRd1   = 10'b0000000010,
    SRd2   = 10'b0000000100,
    SMul   = 10'b0000001000,
    SDivIn = 10'b0000010000,
    SDiv   = 10'b0000100000,
    SDivFx = 10'b0001000000,
    SPush1 = 10'b0010000000,
    SPush2 = 10'b0100000000,
    STop   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] mem [StackDepth];
  logic [31:0] rdata_q;
  logic [AddrW-1:0] raddr;
  logic rd_en;
  logic [AddrW-1:0] waddr;
  logic [31:0] wdata;
  logic we;

  logic [CntW-1:0] dep_q, dep_d;
  kind_e kind_q, kind_d;
  logic signed [31:0] a_q, a_d, b_q, b_d;
  logic [2:0] st_q, st_d;
  logic [1:0] npush_q, npush_d;
  logic signed [31:0] p1_q, p1_d, p2_q, p2_d;
  logic signed [63:0] prod_q, prod_d;
  logic [63:0] num_q, num_d;   // dividend magnitude shifting out
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dsr_q, dsr_d;
  logic neg_q, neg_d;
  logic [5:0] it_q, it_d;
  logic mod_q, mod_d;
  logic done_q, done_d;
  rpn_out_t res_q, res_d;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata_q <= mem[raddr];
  end

  function automatic logic [2:0] err(input logic [2:0] cur, input status_e code);
    return (cur == StOk) ? code : cur;
  endfunction

  // number of pops needed by a kind
  function automatic logic [1:0] npop(input kind_e k);
    case (k)
      KindAdd, KindSub, KindMul, KindDiv, KindMod, KindSwap: return 2'd2;
      KindPeek, KindDup: return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  logic signed [65:0] sum_c;
  logic signed [63:0] mq_c;
  logic [32:0] trial;
  logic signed [31:0] ib_c, ia_c;
  logic [15:0] ia_mag, ib_mag;

  always_comb begin
    state_d = state_q; dep_d = dep_q; kind_d = kind_q; a_d = a_q; b_d = b_q;
    st_d = st_q; npush_d = npush_q; p1_d = p1_q; p2_d = p2_q; prod_d = prod_q;
    num_d = num_q; quo_d = quo_q; rem_d = rem_q; dsr_d = dsr_q; neg_d = neg_q;
    it_d = it_q; mod_d = mod_q; done_d = 1'b0; res_d = res_q;
    cmd_pop_o = 1'b0; rd_en = 1'b0; raddr = '0; we = 1'b0; waddr = '0; wdata = '0;
    sum_c = '0; mq_c = '0; trial = '0; ib_c = '0; ia_c = '0; ia_mag = '0; ib_mag = '0;
    case (state_q)
      SIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          kind_d = cmd_i.kind;
          st_d = StOk;
          npush_d = 2'd0;
          a_d = '0; b_d = '0;
          case (cmd_i.kind)
            KindNumber: begin
              p1_d = cmd_i.value; npush_d = 2'd1; state_d = SPush1;
            end
            KindClear: begin
              dep_d = '0; state_d = STop;
            end
            KindShowTop: begin
              if (dep_q == '0) st_d = StEmpty;
              state_d = STop;
            end
            KindUnknown: begin
              st_d = StUnknown; state_d = STop;
            end
            default: begin
              // first pop
              if (dep_q != '0) begin
                rd_en = 1'b1; raddr = AddrW'(dep_q - 1'b1);
              end
              state_d = SRd1;
            end
          endcase
        end
      end
      SRd1: begin
        // b (or a for peek/dup first pop) arrives
        if (dep_q != '0) begin
          b_d = rdata_q; dep_d = dep_q - 1'b1;
        end else begin
          b_d = '0; st_d = err(st_q, StEmpty);
        end
        if (npop(kind_q) == 2'd1) begin
          p1_d = (dep_q != '0) ? rdata_q : '0;
          p2_d = p1_d; npush_d = (kind_q == KindDup) ? 2'd2 : 2'd1;
          state_d = SPush1;
        end else begin
          b_d = (dep_q != '0) ? rdata_q : '0;
          ib_c = b_d / 32'sd65536;
          if ((kind_q == KindDiv && b_d == '0) || (kind_q == KindMod && b_d[31:16] == 16'd0)
              || (kind_q == KindMod && b_d[31:16] == 16'hffff && b_d[15:0] != 16'd0)) begin
            st_d = err(st_d, StZdiv);
            state_d = STop;
          end else begin
            if (dep_d != '0) begin
              rd_en = 1'b1; raddr = AddrW'(dep_d - 1'b1);
            end
            state_d = SRd2;
          end
        end
      end
      SRd2: begin
        if (dep_q != '0) begin
          a_d = rdata_q; dep_d = dep_q - 1'b1;
        end else begin
          a_d = '0; st_d = err(st_q, StEmpty);
        end
        npush_d = 2'd1;
        case (kind_q)
          KindAdd: begin
            sum_c = 66'(a_d) + 66'(b_q); p1_d = sat32(sum_c); state_d = SPush1;
          end
          KindSub: begin
            sum_c = 66'(a_d) - 66'(b_q); p1_d = sat32(sum_c); state_d = SPush1;
          end
          KindMul: begin
            prod_d = 64'(a_d) * 64'(b_q); state_d = SMul;
          end
          KindSwap: begin
            // pushes first popped then second popped
            p1_d = b_q; p2_d = a_d; npush_d = 2'd2; state_d = SPush1;
          end
          KindDiv: begin
            mod_d = 1'b0;
            neg_d = a_d[31] ^ b_q[31];
            num_d = {(a_d[31] ? 32'(-a_d) : 32'(a_d)), 32'd0};
            dsr_d = b_q[31] ? 32'(-b_q) : 32'(b_q);
            state_d = SDivIn;
          end
          default: begin // mod on integer parts, truncated
            mod_d = 1'b1;
            ia_c = a_d / 32'sd65536; ib_c = b_q / 32'sd65536;
            ia_mag = ia_c[31] ? 16'(-ia_c) : 16'(ia_c);
            ib_mag = ib_c[31] ? 16'(-ib_c) : 16'(ib_c);
            neg_d = ia_c[31];
            num_d = {ia_mag, 48'd0};
            dsr_d = {16'd0, ib_mag};
            state_d = SDivIn;
          end
        endcase
      end
      SMul: begin
        mq_c = prod_q >>> 16;
        p1_d = sat32(66'(mq_c));
        state_d = SPush1;
      end
      SDivIn: begin
        rem_d = '0; quo_d = '0;
        it_d = mod_q ? 6'd15 : 6'd47;
        state_d = SDiv;
      end
      SDiv: begin
        // restoring division, one bit a cycle
        trial = {rem_q[31:0], num_q[63]} - {1'b0, dsr_q};
        num_d = {num_q[62:0], 1'b0};
        if (!trial[32]) begin
          rem_d = trial; quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = {rem_q[31:0], num_q[63]}; quo_d = {quo_q[62:0], 1'b0};
        end
        if (it_q == '0) state_d = SDivFx;
        else it_d = it_q - 1'b1;
      end
      SDivFx: begin
        if (mod_q) begin
          p1_d = neg_q ? -{rem_q[15:0], 16'd0} : {rem_q[15:0], 16'd0};
        end else begin
          sum_c = neg_q ? -66'(quo_q[47:0]) : 66'(quo_q[47:0]);
          p1_d = sat32(sum_c);
        end
        state_d = SPush1;
      end
      SPush1: begin
        if (dep_q < CntW'(StackDepth)) begin
          we = 1'b1; waddr = AddrW'(dep_q); wdata = p1_q; dep_d = dep_q + 1'b1;
        end else st_d = err(st_q, StFull);
        state_d = (npush_q == 2'd2) ? SPush2 : STop;
      end
      SPush2: begin
        if (dep_q < CntW'(StackDepth)) begin
          we = 1'b1; waddr = AddrW'(dep_q); wdata = p2_q; dep_d = dep_q + 1'b1;
        end else st_d = err(st_q, StFull);
        state_d = STop;
      end
      STop: begin
        // top is read once writes have settled
        if (dep_q != '0) begin
          rd_en = 1'b1; raddr = AddrW'(dep_q - 1'b1);
        end
        res_d.stack_depth = 7'(dep_q);
        res_d.status = st_q;
        res_d.show = (kind_q == KindPeek) || (kind_q == KindShowTop);
        done_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; dep_q <= '0; done_q <= 1'b0;
    end else begin
      state_q <= state_d; dep_q <= dep_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; a_q <= a_d; b_q <= b_d; st_q <= st_d; npush_q <= npush_d;
    p1_q <= p1_d; p2_q <= p2_d; prod_q <= prod_d; num_q <= num_d; quo_q <= quo_d;
    rem_q <= rem_d; dsr_q <= dsr_d; neg_q <= neg_d; it_q <= it_d; mod_q <= mod_d;
    res_q <= res_d;
  end

  assign busy_o = (state_q != SIdle) || done_q;
  assign done_o = done_q;
  always_comb begin
    res_o = res_q;
    res_o.top_value = (res_q.stack_depth != '0 || dep_q != '0) ? rdata_q : '0;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) dep_q <= CntW'(StackDepth))
    else $error("depth beyond stack size");
  assert property (@(posedge clk_i) disable iff (!rst_ni) we |-> waddr == AddrW'(dep_q))
    else $error("write not at top");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(state_q) == STop)
    else $error("result without top read");
endmodule

// ===== src/rpn_stack_calculator.sv =====
// top level of the rpn stack calculator
// stack commands and add, sub, mul finish without the divider; mod and div also run the
// one-bit-a-cycle back end divider, which runs longer for div than for mod
// throughput: one item at a time; busy stays high through the strobe cycle, next transfer after it
// reset: asynchronous active low, empties the stack; stack contents are not cleared
// the result is on res_o for one cycle with done_o; the receiver cannot stall
module rpn_stack_calculator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  rpn_pkg::rpn_in_t  in_i,
  output logic              busy,
  output logic              done_o,
  output rpn_pkg::rpn_out_t res_o
);
  import rpn_pkg::*;

  logic     cmd_valid, cmd_pop, back_busy;
  rpn_cmd_t cmd;

  rpn_front u_front (
    .clk_i, .rst_ni, .start_i(start), .in_i, .busy_o(busy),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop), .back_busy_i(back_busy)
  );

  rpn_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .busy_o(back_busy), .done_o, .res_o
  );
endmodule
